@@ design/rbfh_pkg.sv @@
// rbfh_pkg: shared widths, codes, beat payload types and saturation helper
// for the ray/box face hit unit; used by every module of the block, no dependencies
package rbfh_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int IdWidth    = 16;
  localparam int FaceWidth  = 3;
  localparam int NumAxes    = 3;
  localparam int CfgIdxWidth = 3;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int DivBits    = DiffWidth + FracBits;
  localparam int MagWidth   = CoordWidth;
  localparam int ProdWidth  = 2 * CoordWidth;
  localparam int StepWidth  = ProdWidth - FracBits;
  localparam int SumWidth   = StepWidth + 1;

  typedef logic signed [CoordWidth-1:0] coord_t;

  localparam coord_t CoordMax = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordWidth-1){1'b0}}};

  typedef enum logic [FaceWidth-1:0] {
    FaceNone = 3'd0,
    FaceXmin = 3'd1,
    FaceXmax = 3'd2,
    FaceYmin = 3'd3,
    FaceYmax = 3'd4,
    FaceZmin = 3'd5,
    FaceZmax = 3'd6
  } face_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegMinX = 3'd0,
    RegMinY = 3'd1,
    RegMinZ = 3'd2,
    RegMaxX = 3'd3,
    RegMaxY = 3'd4,
    RegMaxZ = 3'd5,
    RegBoxId = 3'd6
  } reg_idx_e;

  typedef struct packed {
    coord_t [NumAxes-1:0] lo;
    coord_t [NumAxes-1:0] hi;
  } box_t;

  // nq holds the remaining dividend bits on top and the quotient bits below
  typedef struct packed {
    coord_t [NumAxes-1:0]                pos;
    coord_t [NumAxes-1:0]                dir;
    coord_t [NumAxes-1:0]                plane;
    logic   [NumAxes-1:0]                neg;
    logic   [NumAxes-1:0][DivBits-1:0]   nq;
    logic   [NumAxes-1:0][MagWidth-1:0]  den;
    logic   [NumAxes-1:0][MagWidth-1:0]  rem;
  } div_t;

  typedef struct packed {
    coord_t [NumAxes-1:0] t;
    coord_t [NumAxes-1:0] pos;
    coord_t [NumAxes-1:0] dir;
    coord_t [NumAxes-1:0] plane;
  } ray_t;

  function automatic coord_t sat_coord(input logic signed [SumWidth-1:0] v);
    coord_t r;
    if ((&v[SumWidth-1:CoordWidth-1]) || !(|v[SumWidth-1:CoordWidth-1])) begin
      r = v[CoordWidth-1:0];
    end else if (v[SumWidth-1]) begin
      r = CoordMin;
    end else begin
      r = CoordMax;
    end
    return r;
  endfunction

endpackage

@@ design/rbfh_div_cell.sv @@
// rbfh_div_cell: one restoring division cell, one quotient bit per axis per beat
// depends on rbfh_pkg
module rbfh_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  rbfh_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output rbfh_pkg::div_t data_o
);

  logic           valid_q;
  rbfh_pkg::div_t data_q, data_d;
  logic [rbfh_pkg::MagWidth:0] trial [rbfh_pkg::NumAxes];

  always_comb begin
    data_d = data_i;
    for (int a = 0; a < rbfh_pkg::NumAxes; a++) begin
      trial[a] = {data_i.rem[a], data_i.nq[a][rbfh_pkg::DivBits-1]};
      if (trial[a] >= {1'b0, data_i.den[a]}) begin
        data_d.rem[a] = rbfh_pkg::MagWidth'(trial[a] - {1'b0, data_i.den[a]});
        data_d.nq[a]  = {data_i.nq[a][rbfh_pkg::DivBits-2:0], 1'b1};
      end else begin
        data_d.rem[a] = trial[a][rbfh_pkg::MagWidth-1:0];
        data_d.nq[a]  = {data_i.nq[a][rbfh_pkg::DivBits-2:0], 1'b0};
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ design/rbfh_hit_stage.sv @@
// rbfh_hit_stage: quotient saturation, hit point products, extent test and face pick
// three registered cells; depends on rbfh_pkg
module rbfh_hit_stage (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  rbfh_pkg::div_t           data_i,
  input  rbfh_pkg::box_t           box_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output rbfh_pkg::face_e          face_o,
  output rbfh_pkg::coord_t         dist_o,
  output rbfh_pkg::coord_t [rbfh_pkg::NumAxes-1:0] pt_o
);

  localparam logic [rbfh_pkg::DivBits-1:0] QPosMax =
    {{(rbfh_pkg::DivBits-rbfh_pkg::CoordWidth+1){1'b0}}, {(rbfh_pkg::CoordWidth-1){1'b1}}};
  localparam logic [rbfh_pkg::DivBits-1:0] QNegMax = QPosMax + 1'b1;

  logic vt_q, vm_q, vr_q;
  logic rdy_t, rdy_m, rdy_r;

  rbfh_pkg::ray_t rt_d, rt_q, rm_q;
  logic signed [rbfh_pkg::ProdWidth-1:0] prod_d [rbfh_pkg::NumAxes][2];
  logic signed [rbfh_pkg::ProdWidth-1:0] prod_q [rbfh_pkg::NumAxes][2];

  rbfh_pkg::face_e  face_d, face_q;
  rbfh_pkg::coord_t dist_d, dist_q;
  rbfh_pkg::coord_t [rbfh_pkg::NumAxes-1:0] pt_d, pt_q;

  assign rdy_r   = !vr_q || ready_i;
  assign rdy_m   = !vm_q || rdy_r;
  assign rdy_t   = !vt_q || rdy_m;
  assign ready_o = rdy_t;

  // signed, saturated distance
  logic [rbfh_pkg::DivBits-1:0] qneg [rbfh_pkg::NumAxes];
  always_comb begin
    rt_d.pos   = data_i.pos;
    rt_d.dir   = data_i.dir;
    rt_d.plane = data_i.plane;
    for (int a = 0; a < rbfh_pkg::NumAxes; a++) begin
      qneg[a] = '0 - data_i.nq[a];
      if (data_i.neg[a]) begin
        rt_d.t[a] = (data_i.nq[a] > QNegMax) ? rbfh_pkg::CoordMin
                                              : qneg[a][rbfh_pkg::CoordWidth-1:0];
      end else begin
        rt_d.t[a] = (data_i.nq[a] > QPosMax) ? rbfh_pkg::CoordMax
                                              : data_i.nq[a][rbfh_pkg::CoordWidth-1:0];
      end
    end
  end

  // t times the other two direction components
  for (genvar ga = 0; ga < rbfh_pkg::NumAxes; ga++) begin : g_axis
    for (genvar gj = 0; gj < 2; gj++) begin : g_other
      localparam int K = (ga + gj + 1) % rbfh_pkg::NumAxes;
      assign prod_d[ga][gj] = $signed(rt_q.t[ga]) * $signed(rt_q.dir[K]);
    end
  end

  // hit point, extent test, later axis wins
  logic signed [rbfh_pkg::StepWidth-1:0] step;
  logic signed [rbfh_pkg::SumWidth-1:0]  sum;
  rbfh_pkg::coord_t [rbfh_pkg::NumAxes-1:0] pt;
  logic ok;
  int   j;
  always_comb begin
    face_d = rbfh_pkg::FaceNone;
    dist_d = rbfh_pkg::CoordMax;
    pt_d   = '0;
    step   = '0;
    sum    = '0;
    pt     = '0;
    ok     = 1'b0;
    j      = 0;
    for (int a = 0; a < rbfh_pkg::NumAxes; a++) begin
      ok = (rm_q.dir[a] != '0);
      for (int k = 0; k < rbfh_pkg::NumAxes; k++) begin
        if (k == a) begin
          pt[k] = rm_q.plane[a];
        end else begin
          j     = (k - a + 2) % rbfh_pkg::NumAxes;
          step  = prod_q[a][j][rbfh_pkg::ProdWidth-1:rbfh_pkg::FracBits];
          sum   = rbfh_pkg::SumWidth'(step) + rbfh_pkg::SumWidth'(rm_q.pos[k]);
          pt[k] = rbfh_pkg::sat_coord(sum);
          if (pt[k] < box_i.lo[k] || pt[k] > box_i.hi[k]) begin
            ok = 1'b0;
          end
        end
      end
      if (ok) begin
        dist_d = rm_q.t[a];
        pt_d   = pt;
        case (a)
          0:       face_d = rm_q.dir[a][rbfh_pkg::CoordWidth-1] ? rbfh_pkg::FaceXmax
                                                                 : rbfh_pkg::FaceXmin;
          1:       face_d = rm_q.dir[a][rbfh_pkg::CoordWidth-1] ? rbfh_pkg::FaceYmax
                                                                 : rbfh_pkg::FaceYmin;
          default: face_d = rm_q.dir[a][rbfh_pkg::CoordWidth-1] ? rbfh_pkg::FaceZmax
                                                                 : rbfh_pkg::FaceZmin;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q <= 1'b0;
      vm_q <= 1'b0;
      vr_q <= 1'b0;
    end else begin
      if (rdy_t) vt_q <= valid_i;
      if (rdy_m) vm_q <= vt_q;
      if (rdy_r) vr_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_t && valid_i) begin
      rt_q <= rt_d;
    end
    if (rdy_m && vt_q) begin
      rm_q   <= rt_q;
      prod_q <= prod_d;
    end
    if (rdy_r && vm_q) begin
      face_q <= face_d;
      dist_q <= dist_d;
      pt_q   <= pt_d;
    end
  end

  assign valid_o = vr_q;
  assign face_o  = face_q;
  assign dist_o  = dist_q;
  assign pt_o    = pt_q;

endmodule

@@ design/ray_box_face_hit_unit.sv @@
// ray_box_face_hit_unit: top level, box registers, divider cell row and hit stage
// depends on rbfh_pkg, rbfh_div_cell, rbfh_hit_stage
//
//   port group | direction | handshake            | beat
//   cfg        | in        | cfg_we_i             | cfg_idx_i, cfg_data_i
//   in         | in        | in_valid_i/in_ready_o | pos_*_i, dir_*_i
//   out        | out       | out_valid_o/out_ready_i | hit_box_o .. hit_z_o
//
// one ray per cycle unless the output stalls; 49 divider cells
// (one quotient bit each) plus distance saturation, product and hit check stages
// every cell has its own valid bit, so bubbles close up under an output stall
// reset clears the box registers and all valid bits; no clearing pass
module ray_box_face_hit_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rbfh_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [rbfh_pkg::CoordWidth-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [rbfh_pkg::CoordWidth-1:0] pos_x_i,
  input  logic signed [rbfh_pkg::CoordWidth-1:0] pos_y_i,
  input  logic signed [rbfh_pkg::CoordWidth-1:0] pos_z_i,
  input  logic signed [rbfh_pkg::CoordWidth-1:0] dir_x_i,
  input  logic signed [rbfh_pkg::CoordWidth-1:0] dir_y_i,
  input  logic signed [rbfh_pkg::CoordWidth-1:0] dir_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rbfh_pkg::IdWidth-1:0]        hit_box_o,
  output logic [rbfh_pkg::FaceWidth-1:0]      face_code_o,
  output logic signed [rbfh_pkg::CoordWidth-1:0] hit_distance_o,
  output logic signed [rbfh_pkg::CoordWidth-1:0] hit_x_o,
  output logic signed [rbfh_pkg::CoordWidth-1:0] hit_y_o,
  output logic signed [rbfh_pkg::CoordWidth-1:0] hit_z_o
);

  rbfh_pkg::box_t                  box_q;
  logic [rbfh_pkg::IdWidth-1:0]    id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
      id_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbfh_pkg::RegMinX:  box_q.lo[0] <= cfg_data_i;
        rbfh_pkg::RegMinY:  box_q.lo[1] <= cfg_data_i;
        rbfh_pkg::RegMinZ:  box_q.lo[2] <= cfg_data_i;
        rbfh_pkg::RegMaxX:  box_q.hi[0] <= cfg_data_i;
        rbfh_pkg::RegMaxY:  box_q.hi[1] <= cfg_data_i;
        rbfh_pkg::RegMaxZ:  box_q.hi[2] <= cfg_data_i;
        rbfh_pkg::RegBoxId: id_q <= cfg_data_i[rbfh_pkg::IdWidth-1:0];
        default: ;
      endcase
    end
  end

  // near plane, dividend and divisor magnitudes
  rbfh_pkg::coord_t [rbfh_pkg::NumAxes-1:0] pos, dir;
  logic signed [rbfh_pkg::DiffWidth-1:0] diff [rbfh_pkg::NumAxes];
  logic [rbfh_pkg::DiffWidth-1:0] mag [rbfh_pkg::NumAxes];
  rbfh_pkg::div_t prep;

  assign pos = {pos_z_i, pos_y_i, pos_x_i};
  assign dir = {dir_z_i, dir_y_i, dir_x_i};

  always_comb begin
    prep     = '0;
    prep.pos = pos;
    prep.dir = dir;
    for (int a = 0; a < rbfh_pkg::NumAxes; a++) begin
      prep.plane[a] = (!dir[a][rbfh_pkg::CoordWidth-1] && (dir[a] != '0)) ? box_q.lo[a]
                                                                          : box_q.hi[a];
      diff[a] = rbfh_pkg::DiffWidth'(prep.plane[a]) - rbfh_pkg::DiffWidth'(pos[a]);
      mag[a]  = diff[a][rbfh_pkg::DiffWidth-1] ? ('0 - diff[a]) : diff[a];
      prep.nq[a]  = rbfh_pkg::DivBits'(mag[a]) << rbfh_pkg::FracBits;
      prep.den[a] = dir[a][rbfh_pkg::CoordWidth-1] ? ('0 - dir[a]) : dir[a];
      prep.neg[a] = diff[a][rbfh_pkg::DiffWidth-1] ^ dir[a][rbfh_pkg::CoordWidth-1];
    end
  end

  logic           valid_c [rbfh_pkg::DivBits+1];
  logic           ready_c [rbfh_pkg::DivBits+1];
  rbfh_pkg::div_t data_c  [rbfh_pkg::DivBits+1];

  assign valid_c[0] = in_valid_i;
  assign data_c[0]  = prep;
  assign in_ready_o = ready_c[0];

  for (genvar gi = 0; gi < rbfh_pkg::DivBits; gi++) begin : g_cell
    rbfh_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[gi]),
      .ready_o (ready_c[gi]),
      .data_i  (data_c[gi]),
      .valid_o (valid_c[gi+1]),
      .ready_i (ready_c[gi+1]),
      .data_o  (data_c[gi+1])
    );
  end

  rbfh_pkg::face_e  face;
  rbfh_pkg::coord_t hit_dist;
  rbfh_pkg::coord_t [rbfh_pkg::NumAxes-1:0] pt;

  rbfh_hit_stage u_hit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_c[rbfh_pkg::DivBits]),
    .ready_o (ready_c[rbfh_pkg::DivBits]),
    .data_i  (data_c[rbfh_pkg::DivBits]),
    .box_i   (box_q),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .face_o  (face),
    .dist_o  (hit_dist),
    .pt_o    (pt)
  );

  assign hit_box_o      = id_q;
  assign face_code_o    = face;
  assign hit_distance_o = hit_dist;
  assign hit_x_o        = pt[0];
  assign hit_y_o        = pt[1];
  assign hit_z_o        = pt[2];

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output");

  a_miss_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && face == rbfh_pkg::FaceNone |-> hit_distance_o == rbfh_pkg::CoordMax)
    else $error("miss without maximum distance");

  a_miss_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && face == rbfh_pkg::FaceNone |-> hit_x_o == '0 && hit_y_o == '0
    && hit_z_o == '0)
    else $error("miss with nonzero point");

  a_xmin_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && face == rbfh_pkg::FaceXmin |-> hit_x_o == box_q.lo[0])
    else $error("x min face off its plane");

endmodule
